[rtl/core/fcrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuel-cut relay sequencer package
// Shared codes, register indexes and structured types for the sequencer.
// ----------------------------------------------------------------------------
package fcrs_pkg;

  // Command carried with each input word.
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_OPEN    = 2'd1,
    CMD_CLOSE   = 2'd2,
    CMD_RESTORE = 2'd3
  } cmd_e;

  // Sequencer step. Codes above CHK_CLOSE are unused and behave as idle.
  typedef enum logic [2:0] {
    STEP_IDLE      = 3'd0,
    STEP_OPEN      = 3'd1,
    STEP_CLOSE     = 3'd2,
    STEP_CHK_OPEN  = 3'd3,
    STEP_CHK_CLOSE = 3'd4
  } step_e;

  // Nonvolatile record values.
  typedef enum logic [1:0] {
    REC_EMPTY  = 2'd0,
    REC_OPEN   = 2'd1,
    REC_CLOSED = 2'd2
  } rec_e;

  // Tick period requests.
  typedef enum logic [1:0] {
    PER_SAME  = 2'd0,
    PER_FAST  = 2'd1,
    PER_ONE   = 2'd2,
    PER_THREE = 2'd3
  } period_e;

  // Configuration register indexes (word address bits [3:2]).
  typedef enum logic [1:0] {
    REG_SPEED_LIMIT  = 2'd0,
    REG_RETRY_LIMIT  = 2'd1,
    REG_PULSE_LIMIT  = 2'd2,
    REG_SPEED_SOURCE = 2'd3
  } reg_e;

  localparam logic [7:0] SPEED_LIMIT_RST  = 8'd20;
  localparam logic [2:0] RETRY_LIMIT_RST  = 3'd3;
  localparam logic [3:0] PULSE_LIMIT_RST  = 4'd10;
  localparam logic       SPEED_SOURCE_RST = 1'b0;

  typedef struct packed {
    logic [7:0] speed_limit;
    logic [2:0] retry_limit;
    logic [3:0] pulse_limit;
    logic       speed_source;
  } cfg_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] pulse_speed;
    logic [7:0] gps_speed;
    logic       pin_level;
    logic       stored_closed;
  } item_t;

  typedef struct packed {
    step_e      step;
    rec_e       latched;
    logic [2:0] retry_count;
    logic [3:0] pulse_count;
    logic       drive_level;
    logic       status_bit;
  } state_t;

  typedef struct packed {
    logic       drive_cut;
    logic       persist_valid;
    rec_e       persist_value;
    period_e    next_period;
    logic       task_active;
    logic       status_valid;
    logic       cut_status;
  } result_t;

endpackage

[rtl/core/fuel_cutoff_relay_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuel-cut relay sequencer
// Steps a fuel-cut relay through open, pulsed close, latch and level checks.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake               Contents
// s_axis    in   tvalid/tready           tuser: command; tdata: speeds, pin, record
// m_axis    out  tvalid/tready           tdata: drive, persist, period, status
// apb       in   psel/penable/pready     four settings at byte addresses 0, 4, 8, 12
//
// Each word passes an input register and a result register. The word lands in
// the input register at its accepting edge and its result is loaded into the
// result register once that register is free. A new word is accepted every
// cycle while m_axis_tready is high; the sequencer state is updated together
// with the move of a word from the input register into the result register.
// Reset is asynchronous and active low: the sequencer returns to idle with
// the relay open, the record empty and the settings at their defaults.
// A stall on m_axis holds the result register; the input register still takes
// one more word, and s_axis_tready falls only once both registers are full.
//
module fuel_cutoff_relay_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] pulse_speed, [15:8] gps_speed, [16] pin_level, [17] stored_closed,
  // [23:18] zero
  input  logic [23:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] drive_cut, [1] persist_valid, [3:2] persist_value, [5:4] next_period,
  // [6] task_active, [7] status_valid, [8] cut_status, [15:9] zero
  output logic [15:0] m_axis_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fcrs_pkg::cfg_t    cfg;
  fcrs_pkg::item_t   in_q, in_d;
  logic              in_valid_q, in_valid_d;
  fcrs_pkg::state_t  st_q, st_d, st_next;
  fcrs_pkg::result_t out_q, out_d, step_res;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              fire;
  logic              in_take;

  fcrs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fcrs_step u_step (
    .cfg_i    (cfg),
    .state_i  (st_q),
    .item_i   (in_q),
    .state_o  (st_next),
    .result_o (step_res)
  );

  // The result register frees up when empty or when its word is taken.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    in_d       = in_q;
    if (in_take) begin
      in_valid_d           = 1'b1;
      in_d.cmd             = fcrs_pkg::cmd_e'(s_axis_tuser);
      in_d.pulse_speed     = s_axis_tdata[7:0];
      in_d.gps_speed       = s_axis_tdata[15:8];
      in_d.pin_level       = s_axis_tdata[16];
      in_d.stored_closed   = s_axis_tdata[17];
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    st_d        = st_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      st_d        = st_next;
      out_d       = step_res;
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      st_q        <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.cut_status, out_q.status_valid, out_q.task_active,
                          out_q.next_period, out_q.persist_value, out_q.persist_valid,
                          out_q.drive_cut};

  // An idle sequencer has always cleared its retry and pulse counters.
  a_idle_counters_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.step == fcrs_pkg::STEP_IDLE) |-> (st_q.retry_count == 3'd0 &&
                                            st_q.pulse_count == 4'd0))
    else $error("idle sequencer holds nonzero counters");

  // A word that leaves the input register always lands in the result register.
  a_fire_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed word did not reach the result register");

  // No record value is reported without a record write.
  a_persist_value_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.persist_valid) |->
      (out_q.persist_value == fcrs_pkg::REC_EMPTY))
    else $error("record value without record write");

  // A status report only comes when no sequence is active.
  a_status_ends_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status_valid) |-> !out_q.task_active)
    else $error("status reported while sequence still active");

endmodule

[rtl/core/fcrs_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuel-cut relay sequencer configuration registers
// APB-style register file holding the speed, retry, pulse and source settings.
// ----------------------------------------------------------------------------
module fcrs_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output fcrs_pkg::cfg_t     cfg_o
);

  fcrs_pkg::cfg_t cfg_q, cfg_d;
  fcrs_pkg::reg_e idx;
  logic           wr_en;

  assign idx    = fcrs_pkg::reg_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        fcrs_pkg::REG_SPEED_LIMIT:  cfg_d.speed_limit  = pwdata[7:0];
        fcrs_pkg::REG_RETRY_LIMIT:  cfg_d.retry_limit  = pwdata[2:0];
        fcrs_pkg::REG_PULSE_LIMIT:  cfg_d.pulse_limit  = pwdata[3:0];
        fcrs_pkg::REG_SPEED_SOURCE: cfg_d.speed_source = pwdata[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fcrs_pkg::REG_SPEED_LIMIT:  prdata = {24'd0, cfg_q.speed_limit};
      fcrs_pkg::REG_RETRY_LIMIT:  prdata = {29'd0, cfg_q.retry_limit};
      fcrs_pkg::REG_PULSE_LIMIT:  prdata = {28'd0, cfg_q.pulse_limit};
      fcrs_pkg::REG_SPEED_SOURCE: prdata = {31'd0, cfg_q.speed_source};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_limit  <= fcrs_pkg::SPEED_LIMIT_RST;
      cfg_q.retry_limit  <= fcrs_pkg::RETRY_LIMIT_RST;
      cfg_q.pulse_limit  <= fcrs_pkg::PULSE_LIMIT_RST;
      cfg_q.speed_source <= fcrs_pkg::SPEED_SOURCE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/fcrs_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuel-cut relay sequencer step logic
// Next-state and result logic for one command or tick word.
// ----------------------------------------------------------------------------
module fcrs_step (
  input  fcrs_pkg::cfg_t    cfg_i,
  input  fcrs_pkg::state_t  state_i,
  input  fcrs_pkg::item_t   item_i,
  output fcrs_pkg::state_t  state_o,
  output fcrs_pkg::result_t result_o
);

  logic [7:0] speed;
  logic       retry_left;
  logic       pulse_left;
  logic       slow_enough;
  logic [3:0] pulse_inc;

  assign speed       = cfg_i.speed_source ? item_i.gps_speed : item_i.pulse_speed;
  assign retry_left  = state_i.retry_count < cfg_i.retry_limit;
  assign pulse_left  = state_i.pulse_count < cfg_i.pulse_limit;
  assign slow_enough = speed <= cfg_i.speed_limit;
  assign pulse_inc   = 4'(state_i.pulse_count + 4'd1);

  // Next state.
  always_comb begin
    state_o = state_i;
    case (item_i.cmd)
      fcrs_pkg::CMD_OPEN:  state_o.step = fcrs_pkg::STEP_OPEN;
      fcrs_pkg::CMD_CLOSE: state_o.step = fcrs_pkg::STEP_CLOSE;
      fcrs_pkg::CMD_RESTORE: begin
        state_o.latched = fcrs_pkg::REC_EMPTY;
        state_o.step    = item_i.stored_closed ? fcrs_pkg::STEP_CLOSE
                                               : fcrs_pkg::STEP_OPEN;
      end
      default: begin
        case (state_i.step)
          fcrs_pkg::STEP_OPEN: begin
            state_o.pulse_count = 4'd0;
            state_o.latched     = fcrs_pkg::REC_OPEN;
            state_o.drive_level = 1'b0;
            state_o.step        = fcrs_pkg::STEP_CHK_OPEN;
            state_o.retry_count = 3'd0;
          end
          fcrs_pkg::STEP_CHK_OPEN, fcrs_pkg::STEP_CHK_CLOSE: begin
            // The expected level is cut for the close check, open otherwise.
            if ((item_i.pin_level == (state_i.step == fcrs_pkg::STEP_CHK_OPEN))
                && retry_left) begin
              state_o.pulse_count = 4'd0;
              state_o.retry_count = 3'(state_i.retry_count + 3'd1);
              state_o.drive_level = (state_i.step == fcrs_pkg::STEP_CHK_CLOSE);
            end else begin
              state_o.retry_count = 3'd0;
              state_o.pulse_count = 4'd0;
              state_o.status_bit  = item_i.pin_level;
              state_o.step        = fcrs_pkg::STEP_IDLE;
            end
          end
          fcrs_pkg::STEP_CLOSE: begin
            if (state_i.latched == fcrs_pkg::REC_CLOSED) begin
              state_o.step        = fcrs_pkg::STEP_CHK_CLOSE;
              state_o.retry_count = 3'd0;
            end else if (slow_enough) begin
              if (pulse_left) begin
                state_o.pulse_count = pulse_inc;
                state_o.drive_level = pulse_inc[0];
              end else begin
                state_o.drive_level = 1'b1;
                state_o.pulse_count = 4'd0;
                state_o.latched     = fcrs_pkg::REC_CLOSED;
                state_o.step        = fcrs_pkg::STEP_CHK_CLOSE;
                state_o.retry_count = 3'd0;
              end
            end
          end
          default: begin
            state_o.retry_count = 3'd0;
            state_o.pulse_count = 4'd0;
            state_o.status_bit  = item_i.pin_level;
            state_o.step        = fcrs_pkg::STEP_IDLE;
          end
        endcase
      end
    endcase
  end

  // Result fields.
  always_comb begin
    result_o               = '0;
    result_o.persist_value = fcrs_pkg::REC_EMPTY;
    result_o.next_period   = fcrs_pkg::PER_SAME;
    case (item_i.cmd)
      fcrs_pkg::CMD_OPEN, fcrs_pkg::CMD_CLOSE, fcrs_pkg::CMD_RESTORE: begin
        result_o.persist_valid = 1'b1;
        result_o.task_active   = 1'b1;
        if ((item_i.cmd == fcrs_pkg::CMD_CLOSE) ||
            ((item_i.cmd == fcrs_pkg::CMD_RESTORE) && item_i.stored_closed)) begin
          result_o.persist_value = fcrs_pkg::REC_CLOSED;
          result_o.next_period   = fcrs_pkg::PER_ONE;
        end else begin
          result_o.persist_value = fcrs_pkg::REC_OPEN;
          result_o.next_period   = fcrs_pkg::PER_FAST;
        end
      end
      default: begin
        case (state_i.step)
          fcrs_pkg::STEP_OPEN: begin
            result_o.persist_valid = 1'b1;
            result_o.persist_value = fcrs_pkg::REC_OPEN;
            result_o.next_period   = fcrs_pkg::PER_THREE;
            result_o.task_active   = 1'b1;
          end
          fcrs_pkg::STEP_CHK_OPEN, fcrs_pkg::STEP_CHK_CLOSE: begin
            if ((item_i.pin_level == (state_i.step == fcrs_pkg::STEP_CHK_OPEN))
                && retry_left) begin
              result_o.task_active = 1'b1;
            end else begin
              result_o.status_valid = 1'b1;
            end
          end
          fcrs_pkg::STEP_CLOSE: begin
            result_o.task_active = 1'b1;
            if (state_i.latched == fcrs_pkg::REC_CLOSED) begin
              result_o.next_period = fcrs_pkg::PER_THREE;
            end else if (slow_enough && !pulse_left) begin
              result_o.persist_valid = 1'b1;
              result_o.persist_value = fcrs_pkg::REC_CLOSED;
              result_o.next_period   = fcrs_pkg::PER_THREE;
            end
          end
          default: result_o.status_valid = 1'b1;
        endcase
      end
    endcase
    result_o.drive_cut  = state_o.drive_level;
    result_o.cut_status = state_o.status_bit;
  end

endmodule
